/* design/mfma_pkg.sv */
// ----------------------------------------------------------------------------
// mfma_pkg
// Shared constants and controller/datapath handshake types for the
// multi-turn shaft angle unit.
// ----------------------------------------------------------------------------
package mfma_pkg;

    localparam int NUM_PORTS   = 4;
    localparam int NUM_SLOTS   = NUM_PORTS * 2;
    localparam int SLOT_W      = 3;
    localparam int PORT_W      = 2;
    localparam int ID_W        = 11;
    localparam int LEN_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int GEAR_W      = 12;
    localparam int DVD_W       = 31;
    localparam int CNT_W       = 5;

    localparam logic [ID_W-1:0]   ID_FIRST   = 11'h141;
    localparam logic [ID_W-1:0]   ID_SECOND  = 11'h142;
    localparam logic [LEN_W-1:0]  MIN_LEN    = 4'd8;
    localparam logic [GEAR_W-1:0] GEAR_RESET = 12'd36;
    localparam logic [WORD_W:0]   HALF_TURN  = 17'd32768;

    localparam logic signed [WORD_W-1:0] TURN_MIN = 16'sh8000;
    localparam logic signed [WORD_W-1:0] TURN_MAX = 16'sh7FFF;

    // controller -> datapath
    typedef struct packed {
        logic start;   // input beat taken: check, unwrap, load divider
        logic step;    // one restoring divide step
        logic load;    // move finished result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;    // divider is on its final step
    } t_sts;

endpackage

/* design/motor_feedback_multiturn_angle_unit.sv */
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_angle_unit
// Unwraps the 16-bit motor encoder of feedback frames into a turn count per
// motor slot and gives the geared output-shaft angle in binary angle units.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall   port, can_id, length, bytes 1-7
//  out       source     o_out_valid / i_out_stall accepted, slot, raw fields,
//                                                 turns, shaft angle
//  cfg       sink       i_cfg_we                  gear reduction (12 bits)
//
// Each beat passes the accept edge, 31 steps of the one-bit-per-cycle
// restoring divider (31-bit dividend by the gear ratio), then the edge that
// loads the output register. The next beat is taken on the cycle after that.
// A result waiting in the output register does not hold off the next beat; a
// second finished result waits in the datapath until the first is taken.
// Synchronous reset clears the slot seen flags and sets the gear ratio to 36.
//
module motor_feedback_multiturn_angle_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mfma_pkg::GEAR_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [mfma_pkg::PORT_W-1:0]            i_port,
    input  logic [mfma_pkg::ID_W-1:0]              i_can_id,
    input  logic [mfma_pkg::LEN_W-1:0]             i_data_length,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte1,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte2,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte3,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte4,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte5,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte6,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte7,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_accepted,
    output logic [mfma_pkg::SLOT_W-1:0]            o_motor_slot,
    output logic [mfma_pkg::BYTE_W-1:0]            o_temperature,
    output logic [mfma_pkg::WORD_W-1:0]            o_torque_raw,
    output logic [mfma_pkg::WORD_W-1:0]            o_speed_raw,
    output logic [mfma_pkg::WORD_W-1:0]            o_encoder_raw,
    output logic signed [mfma_pkg::WORD_W-1:0]     o_turns,
    output logic [mfma_pkg::WORD_W-1:0]            o_shaft_angle
);

    mfma_pkg::t_cmd w_cmd;
    mfma_pkg::t_sts w_sts;

    mfma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mfma_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_port        (i_port),
        .i_can_id      (i_can_id),
        .i_data_length (i_data_length),
        .i_byte1       (i_byte1),
        .i_byte2       (i_byte2),
        .i_byte3       (i_byte3),
        .i_byte4       (i_byte4),
        .i_byte5       (i_byte5),
        .i_byte6       (i_byte6),
        .i_byte7       (i_byte7),
        .o_accepted    (o_accepted),
        .o_motor_slot  (o_motor_slot),
        .o_temperature (o_temperature),
        .o_torque_raw  (o_torque_raw),
        .o_speed_raw   (o_speed_raw),
        .o_encoder_raw (o_encoder_raw),
        .o_turns       (o_turns),
        .o_shaft_angle (o_shaft_angle)
    );

endmodule

/* design/mfma_ctrl.sv */
// ----------------------------------------------------------------------------
// mfma_ctrl
// Sequencer: takes one frame, runs the divider, hands the result to the
// output register.
// ----------------------------------------------------------------------------
module mfma_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    input  mfma_pkg::t_sts  i_sts,
    output mfma_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_load;

    assign w_load = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);

    always_comb begin
        o_cmd.start = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step  = (r_state == S_DIV);
        o_cmd.load  = w_load;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.last) r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_load)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

endmodule

/* design/mfma_dp.sv */
// ----------------------------------------------------------------------------
// mfma_dp
// Datapath: frame check, per-slot unwrap store, restoring divider for the
// shaft angle, output register.
// ----------------------------------------------------------------------------
module mfma_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mfma_pkg::t_cmd                         i_cmd,
    output mfma_pkg::t_sts                         o_sts,
    input  logic                                   i_cfg_we,
    input  logic [mfma_pkg::GEAR_W-1:0]            i_cfg_data,
    input  logic [mfma_pkg::PORT_W-1:0]            i_port,
    input  logic [mfma_pkg::ID_W-1:0]              i_can_id,
    input  logic [mfma_pkg::LEN_W-1:0]             i_data_length,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte1,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte2,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte3,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte4,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte5,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte6,
    input  logic [mfma_pkg::BYTE_W-1:0]            i_byte7,
    output logic                                   o_accepted,
    output logic [mfma_pkg::SLOT_W-1:0]            o_motor_slot,
    output logic [mfma_pkg::BYTE_W-1:0]            o_temperature,
    output logic [mfma_pkg::WORD_W-1:0]            o_torque_raw,
    output logic [mfma_pkg::WORD_W-1:0]            o_speed_raw,
    output logic [mfma_pkg::WORD_W-1:0]            o_encoder_raw,
    output logic signed [mfma_pkg::WORD_W-1:0]     o_turns,
    output logic [mfma_pkg::WORD_W-1:0]            o_shaft_angle
);

    // per-slot unwrap store
    logic [mfma_pkg::WORD_W-1:0]        r_last_enc [mfma_pkg::NUM_SLOTS];
    logic signed [mfma_pkg::WORD_W-1:0] r_turn_cnt [mfma_pkg::NUM_SLOTS];
    logic [mfma_pkg::NUM_SLOTS-1:0]     r_seen;

    logic [mfma_pkg::GEAR_W-1:0] r_gear;

    // staged fields of the frame in flight
    logic                               r_acc;
    logic [mfma_pkg::SLOT_W-1:0]        r_slot;
    logic [mfma_pkg::BYTE_W-1:0]        r_temp;
    logic [mfma_pkg::WORD_W-1:0]        r_torque;
    logic [mfma_pkg::WORD_W-1:0]        r_speed;
    logic [mfma_pkg::WORD_W-1:0]        r_enc;
    logic signed [mfma_pkg::WORD_W-1:0] r_turns;
    logic                               r_neg;

    // divider
    logic [mfma_pkg::GEAR_W-1:0] r_div;
    logic [mfma_pkg::GEAR_W-1:0] r_rem;
    logic [mfma_pkg::DVD_W-1:0]  r_dvd;
    logic [mfma_pkg::WORD_W-1:0] r_quo;
    logic [mfma_pkg::CNT_W-1:0]  r_cnt;

    // output register
    logic                               r_o_acc;
    logic [mfma_pkg::SLOT_W-1:0]        r_o_slot;
    logic [mfma_pkg::BYTE_W-1:0]        r_o_temp;
    logic [mfma_pkg::WORD_W-1:0]        r_o_torque;
    logic [mfma_pkg::WORD_W-1:0]        r_o_speed;
    logic [mfma_pkg::WORD_W-1:0]        r_o_enc;
    logic signed [mfma_pkg::WORD_W-1:0] r_o_turns;
    logic [mfma_pkg::WORD_W-1:0]        r_o_angle;

    logic                               w_id_ok;
    logic                               w_acc;
    logic [mfma_pkg::SLOT_W-1:0]        w_slot;
    logic [mfma_pkg::WORD_W-1:0]        w_enc;
    logic [mfma_pkg::WORD_W-1:0]        w_prev;
    logic signed [mfma_pkg::WORD_W-1:0] w_t_old;
    logic signed [mfma_pkg::WORD_W-1:0] w_t_new;
    logic signed [mfma_pkg::WORD_W:0]   w_delta;
    logic [2*mfma_pkg::WORD_W-1:0]      w_total;
    logic [mfma_pkg::DVD_W-1:0]         w_mag;
    logic [mfma_pkg::GEAR_W:0]          w_trial;
    logic                               w_qbit;

    always_comb begin
        w_id_ok = (i_can_id == mfma_pkg::ID_FIRST) || (i_can_id == mfma_pkg::ID_SECOND);
        w_acc   = w_id_ok && (i_data_length >= mfma_pkg::MIN_LEN) && (i_byte1 != '0)
                  && (int'(i_port) < mfma_pkg::NUM_PORTS);
        w_slot  = {i_port, (i_can_id == mfma_pkg::ID_SECOND)};
        w_enc   = {i_byte7, i_byte6};
        w_prev  = r_seen[w_slot] ? r_last_enc[w_slot] : w_enc;
        w_t_old = r_seen[w_slot] ? r_turn_cnt[w_slot] : '0;
        w_delta = $signed({1'b0, w_enc}) - $signed({1'b0, w_prev});

        w_t_new = w_t_old;
        if (w_delta > $signed(mfma_pkg::HALF_TURN)) begin
            if (w_t_old != mfma_pkg::TURN_MIN) w_t_new = w_t_old - 16'sd1;
        end else if (w_delta < -$signed(mfma_pkg::HALF_TURN)) begin
            if (w_t_old != mfma_pkg::TURN_MAX) w_t_new = w_t_old + 16'sd1;
        end

        // turns*65536 + encoder is just the concatenation; floor of a
        // negative dividend via one's complement: floor(x/g) = ~(~x / g)
        w_total = {w_t_new, w_enc};
        w_mag   = w_total[2*mfma_pkg::WORD_W-1] ? ~w_total[mfma_pkg::DVD_W-1:0]
                                                 : w_total[mfma_pkg::DVD_W-1:0];

        w_trial = {r_rem, r_dvd[mfma_pkg::DVD_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_div});
    end

    assign o_sts.last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_gear <= mfma_pkg::GEAR_RESET;
        end else begin
            if (i_cfg_we) r_gear <= i_cfg_data;
            if (i_cmd.start && w_acc) r_seen[w_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && w_acc) begin
            r_last_enc[w_slot] <= w_enc;
            r_turn_cnt[w_slot] <= w_t_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            // rejected beats run a zero dividend so every field reads zero
            r_acc    <= w_acc;
            r_slot   <= w_acc ? w_slot : '0;
            r_temp   <= w_acc ? i_byte1 : '0;
            r_torque <= w_acc ? {i_byte3, i_byte2} : '0;
            r_speed  <= w_acc ? {i_byte5, i_byte4} : '0;
            r_enc    <= w_acc ? w_enc : '0;
            r_turns  <= w_acc ? w_t_new : '0;
            r_neg    <= w_acc && w_total[2*mfma_pkg::WORD_W-1];
            r_dvd    <= w_acc ? w_mag : '0;
            r_div    <= (r_gear == '0) ? mfma_pkg::GEAR_W'(1) : r_gear;
            r_rem    <= '0;
            r_quo    <= '0;
            r_cnt    <= mfma_pkg::CNT_W'(mfma_pkg::DVD_W - 1);
        end else if (i_cmd.step) begin
            r_rem <= w_qbit ? mfma_pkg::GEAR_W'(w_trial - {1'b0, r_div})
                            : w_trial[mfma_pkg::GEAR_W-1:0];
            r_dvd <= {r_dvd[mfma_pkg::DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[mfma_pkg::WORD_W-2:0], w_qbit};
            if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_acc    <= r_acc;
            r_o_slot   <= r_slot;
            r_o_temp   <= r_temp;
            r_o_torque <= r_torque;
            r_o_speed  <= r_speed;
            r_o_enc    <= r_enc;
            r_o_turns  <= r_turns;
            r_o_angle  <= r_neg ? ~r_quo : r_quo;
        end
    end

    assign o_accepted    = r_o_acc;
    assign o_motor_slot  = r_o_slot;
    assign o_temperature = r_o_temp;
    assign o_torque_raw  = r_o_torque;
    assign o_speed_raw   = r_o_speed;
    assign o_encoder_raw = r_o_enc;
    assign o_turns       = r_o_turns;
    assign o_shaft_angle = r_o_angle;

endmodule

/* design/mfma_chk.sv */
// ----------------------------------------------------------------------------
// mfma_chk
// Port-level checks for the multi-turn shaft angle unit, bound to the top.
// ----------------------------------------------------------------------------
module mfma_chk (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   o_in_stall,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    input  logic                                   o_accepted,
    input  logic [mfma_pkg::SLOT_W-1:0]            o_motor_slot,
    input  logic [mfma_pkg::BYTE_W-1:0]            o_temperature,
    input  logic signed [mfma_pkg::WORD_W-1:0]     o_turns,
    input  logic [mfma_pkg::WORD_W-1:0]            o_shaft_angle
);

    // a rejected beat carries an all-zero result
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |->
            o_motor_slot == '0 && o_turns == '0 && o_shaft_angle == '0)
        else $error("rejected beat with nonzero fields");

    // an accepted beat always had a nonzero temperature byte
    a_temp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_temperature != '0)
        else $error("accepted beat with zero temperature");

    // one frame at a time: the divider run holds off the next beat
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_shaft_angle))
        else $error("stalled result dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind motor_feedback_multiturn_angle_unit mfma_chk u_mfma_chk (.*);
